// ===== rtl/core/http_date_to_epoch_assert.svh =====
// ---------------------------------------------------------------------------
// HTTP date to epoch: assertion macros
// Shared concurrent assertion forms for the date decoder modules.
// ---------------------------------------------------------------------------
`ifndef HTTP_DATE_TO_EPOCH_ASSERT_SVH
`define HTTP_DATE_TO_EPOCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HDE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HDE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/hde_pkg.sv =====
// ---------------------------------------------------------------------------
// HTTP date to epoch: package
// Shared types, character constants and name tables of the date decoder.
// ---------------------------------------------------------------------------
package hde_pkg;

	localparam int unsigned QueueDepth = 2;

	localparam logic [4:0] DateLen = 5'd29;
	localparam logic [4:0] PosSat  = 5'd30;

	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChComma = 8'h2C;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChColon = 8'h3A;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChG     = 8'h47;
	localparam logic [7:0] ChM     = 8'h4D;
	localparam logic [7:0] ChT     = 8'h54;

	localparam logic [2:0] WdNone  = 3'd7;
	localparam logic [2:0] WdSat   = 3'd6;
	localparam logic [3:0] MonNone = 4'd0;
	localparam logic [3:0] MonFeb  = 4'd2;
	localparam logic [3:0] MonDec  = 4'd12;

	typedef struct packed {
		logic        len_ok;
		logic        fmt_err;
		logic [2:0]  wday;
		logic [3:0]  month;
		logic [6:0]  day;
		logic [13:0] year;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} date_rec_t;

	function automatic logic [2:0] wday_lookup(input logic [15:0] prefix, input logic [7:0] c);
		logic [23:0] key;
		key = {prefix, c};
		unique case (key)
			"Sun":   return 3'd0;
			"Mon":   return 3'd1;
			"Tue":   return 3'd2;
			"Wed":   return 3'd3;
			"Thu":   return 3'd4;
			"Fri":   return 3'd5;
			"Sat":   return 3'd6;
			default: return WdNone;
		endcase
	endfunction

	function automatic logic [3:0] month_lookup(input logic [15:0] prefix, input logic [7:0] c);
		logic [23:0] key;
		key = {prefix, c};
		unique case (key)
			"Jan":   return 4'd1;
			"Feb":   return 4'd2;
			"Mar":   return 4'd3;
			"Apr":   return 4'd4;
			"May":   return 4'd5;
			"Jun":   return 4'd6;
			"Jul":   return 4'd7;
			"Aug":   return 4'd8;
			"Sep":   return 4'd9;
			"Oct":   return 4'd10;
			"Nov":   return 4'd11;
			"Dec":   return 4'd12;
			default: return MonNone;
		endcase
	endfunction

	function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
		unique case (month)
			4'd2:    return leap ? 5'd29 : 5'd28;
			4'd4:    return 5'd30;
			4'd6:    return 5'd30;
			4'd9:    return 5'd30;
			4'd11:   return 5'd30;
			default: return 5'd31;
		endcase
	endfunction

	// Day of a year that starts on the first of March, at the first of each month.
	function automatic logic [8:0] doy_base(input logic [3:0] month);
		unique case (month)
			4'd1:    return 9'd306;
			4'd2:    return 9'd337;
			4'd4:    return 9'd31;
			4'd5:    return 9'd61;
			4'd6:    return 9'd92;
			4'd7:    return 9'd122;
			4'd8:    return 9'd153;
			4'd9:    return 9'd184;
			4'd10:   return 9'd214;
			4'd11:   return 9'd245;
			4'd12:   return 9'd275;
			default: return 9'd0;
		endcase
	endfunction

endpackage

// ===== rtl/core/http_date_to_epoch.sv =====
// ---------------------------------------------------------------------------
// HTTP date to epoch
// Decodes an IMF-fixdate string, one character per transfer, into Unix time.
// ---------------------------------------------------------------------------
// Channel  Dir  tdata                    tuser       tlast
// s_*      in   [7:0] char_in            -           last character of the string
// m_*      out  [38:0] epoch_seconds     valid_res   -
//
// One character is taken every cycle in which s_tready is high.
// A result shows on m_tvalid once its record has passed the record queue and
// the six-stage conversion pipeline behind it.
// arst_n clears the parser state, the queue and all stage valid bits.
// A stall on m_tready fills the pipeline, then the queue, then drops s_tready.
module http_date_to_epoch #(
	parameter int unsigned QUEUE_DEPTH = hde_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [38:0] epoch_seconds, [39] zero
	output logic        m_tuser    // [0] valid_res
);
	import hde_pkg::*;

	logic      q_full, q_push, q_pop, q_not_empty;
	date_rec_t q_in_rec, q_out_rec;

	hde_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (q_in_rec)
	);

	hde_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_rec  (q_in_rec),
		.full      (q_full),
		.pop       (q_pop),
		.pop_rec   (q_out_rec),
		.not_empty (q_not_empty)
	);

	hde_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_not_empty),
		.in_rec   (q_out_rec),
		.in_pop   (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== rtl/core/hde_front.sv =====
// ---------------------------------------------------------------------------
// HTTP date to epoch: character front end
// Checks each character against the fixed date layout and gathers fields.
// ---------------------------------------------------------------------------
module hde_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  logic              q_full,
	output logic              q_push,
	output hde_pkg::date_rec_t q_rec
);
	import hde_pkg::*;

	logic [4:0]  pos_q, pos_n;
	logic        nul_q, nul_n;
	logic        ferr_q, ferr_n;
	logic [2:0]  wday_q, wday_n;
	logic [3:0]  month_q, month_n;
	logic [6:0]  day_q, day_n;
	logic [13:0] year_q, year_n;
	logic [6:0]  hour_q, hour_n;
	logic [6:0]  min_q, min_n;
	logic [6:0]  sec_q, sec_n;
	logic [15:0] shift_q, shift_n;
	logic        is_digit;
	logic [3:0]  dval;
	logic        accept;

	function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] d);
		logic [10:0] t;
		t = 11'({a, 3'b000}) + 11'({a, 1'b0}) + 11'(d);
		return t[6:0];
	endfunction

	function automatic logic [13:0] acc14(input logic [13:0] a, input logic [3:0] d);
		logic [17:0] t;
		t = 18'({a, 3'b000}) + 18'({a, 1'b0}) + 18'(d);
		return t[13:0];
	endfunction

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && s_tlast;
	assign is_digit = (s_tdata >= ChZero) && (s_tdata <= ChNine);
	assign dval     = 4'(s_tdata - ChZero);

	always_comb begin
		pos_n   = pos_q;
		nul_n   = nul_q;
		ferr_n  = ferr_q;
		wday_n  = wday_q;
		month_n = month_q;
		day_n   = day_q;
		year_n  = year_q;
		hour_n  = hour_q;
		min_n   = min_q;
		sec_n   = sec_q;
		shift_n = shift_q;
		if (!nul_q) begin
			if (s_tdata == ChNul) begin
				nul_n = 1'b1;
			end else begin
				unique case (pos_q)
					5'd0, 5'd1, 5'd8, 5'd9: shift_n = {shift_q[7:0], s_tdata};
					5'd2:  wday_n  = wday_lookup(shift_q, s_tdata);
					5'd10: month_n = month_lookup(shift_q, s_tdata);
					5'd3:  if (s_tdata != ChComma) ferr_n = 1'b1;
					5'd4, 5'd7, 5'd11, 5'd16, 5'd25: if (s_tdata != ChSpace) ferr_n = 1'b1;
					5'd19, 5'd22: if (s_tdata != ChColon) ferr_n = 1'b1;
					5'd26: if (s_tdata != ChG) ferr_n = 1'b1;
					5'd27: if (s_tdata != ChM) ferr_n = 1'b1;
					5'd28: if (s_tdata != ChT) ferr_n = 1'b1;
					5'd5, 5'd6: begin
						if (is_digit) day_n = acc7(day_q, dval);
						else ferr_n = 1'b1;
					end
					5'd12, 5'd13, 5'd14, 5'd15: begin
						if (is_digit) year_n = acc14(year_q, dval);
						else ferr_n = 1'b1;
					end
					5'd17, 5'd18: begin
						if (is_digit) hour_n = acc7(hour_q, dval);
						else ferr_n = 1'b1;
					end
					5'd20, 5'd21: begin
						if (is_digit) min_n = acc7(min_q, dval);
						else ferr_n = 1'b1;
					end
					5'd23, 5'd24: begin
						if (is_digit) sec_n = acc7(sec_q, dval);
						else ferr_n = 1'b1;
					end
					default: ;
				endcase
				if (pos_q < PosSat) pos_n = pos_q + 5'd1;
			end
		end
	end

	always_comb begin
		q_rec.len_ok  = (pos_n == DateLen);
		q_rec.fmt_err = ferr_n;
		q_rec.wday    = wday_n;
		q_rec.month   = month_n;
		q_rec.day     = day_n;
		q_rec.year    = year_n;
		q_rec.hour    = hour_n;
		q_rec.minute  = min_n;
		q_rec.second  = sec_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			nul_q   <= 1'b0;
			ferr_q  <= 1'b0;
			wday_q  <= '0;
			month_q <= '0;
			day_q   <= '0;
			year_q  <= '0;
			hour_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			shift_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				pos_q   <= '0;
				nul_q   <= 1'b0;
				ferr_q  <= 1'b0;
				wday_q  <= '0;
				month_q <= '0;
				day_q   <= '0;
				year_q  <= '0;
				hour_q  <= '0;
				min_q   <= '0;
				sec_q   <= '0;
				shift_q <= '0;
			end else begin
				pos_q   <= pos_n;
				nul_q   <= nul_n;
				ferr_q  <= ferr_n;
				wday_q  <= wday_n;
				month_q <= month_n;
				day_q   <= day_n;
				year_q  <= year_n;
				hour_q  <= hour_n;
				min_q   <= min_n;
				sec_q   <= sec_n;
				shift_q <= shift_n;
			end
		end
	end

endmodule

// ===== rtl/core/hde_queue.sv =====
// ---------------------------------------------------------------------------
// HTTP date to epoch: record queue
// Small first-in first-out buffer of decoded date records.
// ---------------------------------------------------------------------------
module hde_queue #(
	parameter int unsigned DEPTH = hde_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hde_pkg::date_rec_t push_rec,
	output logic               full,
	input  logic               pop,
	output hde_pkg::date_rec_t pop_rec,
	output logic               not_empty
);
	import hde_pkg::*;

	`include "http_date_to_epoch_assert.svh"

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	date_rec_t     slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_rec   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`HDE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "queue count past depth")
	`HDE_ASSERT_NEXT(a_push_grows, push && !pop, count_q == $past(count_q) + 1'b1,
		"queue count did not grow on push")

endmodule

// ===== rtl/core/hde_back.sv =====
// ---------------------------------------------------------------------------
// HTTP date to epoch: conversion pipeline
// Range checks, civil-to-days conversion, weekday check and seconds.
// ---------------------------------------------------------------------------
module hde_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  hde_pkg::date_rec_t in_rec,
	output logic               in_pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata,
	output logic               m_tuser
);
	import hde_pkg::*;

	`include "http_date_to_epoch_assert.svh"

	localparam logic [13:0] YearMin     = 14'd1601;
	localparam logic [12:0] Recip400    = 13'd5243;
	localparam logic [12:0] Recip100    = 13'd5243;
	localparam logic [5:0]  Recip100Yoe = 6'd41;
	localparam logic [23:0] DaysEra     = 24'd146097;
	localparam logic signed [24:0] DaysShift = 25'sd719468;
	localparam logic [24:0] WdOffset    = 25'd140004;
	localparam logic signed [38:0] SecDay = 39'sd86400;

	logic en1, en2, en3, en4, en5, en6;

	// Stage 1
	logic        v_s1, ok_s1;
	logic [5:0]  era_s1;
	logic [13:0] y_s1, year_s1;
	logic [7:0]  q100_s1;
	logic [3:0]  month_s1;
	logic [6:0]  day_s1, hour_s1, min_s1, sec_s1;
	logic [8:0]  doy_s1;
	logic [2:0]  wday_s1;
	logic [13:0] y_c;
	logic [26:0] era_prod, q100_prod;
	logic        ok_c1;

	// Stage 2
	logic        v_s2, ok_s2;
	logic [5:0]  era_s2;
	logic [8:0]  yoe_s2, doy_s2;
	logic [6:0]  hour_s2, min_s2, sec_s2;
	logic [2:0]  wday_s2;
	logic [14:0] yoe_wide;
	logic [13:0] rem100_wide;
	logic [6:0]  rem100;
	logic        leap;

	// Stage 3
	logic        v_s3, ok_s3;
	logic [23:0] era146_s3;
	logic [17:0] yoe365_s3;
	logic [6:0]  yoe4_s3;
	logic [1:0]  yq_s3;
	logic [8:0]  doy_s3;
	logic [6:0]  hour_s3, min_s3, sec_s3;
	logic [2:0]  wday_s3;
	logic [13:0] yq_prod;

	// Stage 4
	logic               v_s4, ok_s4;
	logic signed [24:0] days_s4;
	logic [16:0]        tod_s4;
	logic [2:0]         wday_s4;
	logic [23:0]        doe_sum;

	// Stage 5
	logic               v_s5, ok_s5;
	logic signed [38:0] daysec_s5;
	logic [16:0]        tod_s5;
	logic [2:0]         wd_c;

	// Output register
	logic        v_out_q, ok_out_q;
	logic [38:0] epoch_q;

	function automatic logic [2:0] mod7(input logic [24:0] v);
		logic [26:0] w;
		logic [5:0]  s1;
		logic [3:0]  s2;
		logic [2:0]  r;
		w  = {2'b00, v};
		s1 = '0;
		for (int i = 0; i < 9; i++) s1 = s1 + 6'(w[3*i +: 3]);
		s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
		r  = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
		return (r == 3'd7) ? 3'd0 : r;
	endfunction

	assign en6    = !v_out_q || m_tready;
	assign en5    = !v_s5 || en6;
	assign en4    = !v_s4 || en5;
	assign en3    = !v_s3 || en4;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;
	assign in_pop = in_valid && en1;

	always_comb begin
		y_c       = in_rec.year - 14'((in_rec.month <= MonFeb) ? 1 : 0);
		era_prod  = 27'(y_c) * 27'(Recip400);
		q100_prod = 27'(in_rec.year) * 27'(Recip100);
		ok_c1 = in_rec.len_ok && !in_rec.fmt_err && (in_rec.wday <= WdSat) &&
			(in_rec.month != MonNone) && (in_rec.month <= MonDec) &&
			(in_rec.year >= YearMin) && (in_rec.hour <= 7'd23) &&
			(in_rec.minute <= 7'd59) && (in_rec.second <= 7'd59) && (in_rec.day != 7'd0);
	end

	always_comb begin
		yoe_wide    = 15'(y_s1) - 15'(era_s1) * 15'd400;
		rem100_wide = year_s1 - 14'(q100_s1) * 14'd100;
		rem100      = rem100_wide[6:0];
		leap = (year_s1[1:0] == 2'b00) && ((rem100 != 7'd0) || (q100_s1[1:0] == 2'b00));
	end

	assign yq_prod = 14'(yoe_s2) * 14'(Recip100Yoe);

	assign doe_sum = era146_s3 + 24'(yoe365_s3) + 24'(yoe4_s3) + 24'(doy_s3) - 24'(yq_s3);

	assign wd_c = mod7(25'(days_s4) + WdOffset);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_out_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ok_s1    <= ok_c1;
			era_s1   <= era_prod[26:21];
			y_s1     <= y_c;
			q100_s1  <= q100_prod[26:19];
			year_s1  <= in_rec.year;
			month_s1 <= in_rec.month;
			day_s1   <= in_rec.day;
			doy_s1   <= doy_base(in_rec.month) + 9'(in_rec.day) - 9'd1;
			hour_s1  <= in_rec.hour;
			min_s1   <= in_rec.minute;
			sec_s1   <= in_rec.second;
			wday_s1  <= in_rec.wday;
		end
		if (en2) begin
			ok_s2   <= ok_s1 && (day_s1 <= 7'(days_in_month(month_s1, leap)));
			era_s2  <= era_s1;
			yoe_s2  <= yoe_wide[8:0];
			doy_s2  <= doy_s1;
			hour_s2 <= hour_s1;
			min_s2  <= min_s1;
			sec_s2  <= sec_s1;
			wday_s2 <= wday_s1;
		end
		if (en3) begin
			ok_s3     <= ok_s2;
			era146_s3 <= 24'(era_s2) * DaysEra;
			yoe365_s3 <= 18'(yoe_s2) * 18'd365;
			yoe4_s3   <= yoe_s2[8:2];
			yq_s3     <= yq_prod[13:12];
			doy_s3    <= doy_s2;
			hour_s3   <= hour_s2;
			min_s3    <= min_s2;
			sec_s3    <= sec_s2;
			wday_s3   <= wday_s2;
		end
		if (en4) begin
			ok_s4   <= ok_s3;
			days_s4 <= $signed({1'b0, doe_sum}) - DaysShift;
			tod_s4  <= 17'(hour_s3) * 17'd3600 + 17'(min_s3) * 17'd60 + 17'(sec_s3);
			wday_s4 <= wday_s3;
		end
		if (en5) begin
			ok_s5     <= ok_s4 && (wd_c == wday_s4);
			daysec_s5 <= 39'(days_s4) * SecDay;
			tod_s5    <= tod_s4;
		end
		if (en6) begin
			ok_out_q <= ok_s5;
			epoch_q  <= ok_s5 ? 39'(daysec_s5) + 39'(tod_s5) : '0;
		end
	end

	assign m_tvalid = v_out_q;
	assign m_tuser  = ok_out_q;
	assign m_tdata  = {1'b0, epoch_q};

	`HDE_ASSERT_NOW(a_invalid_zero, v_out_q && !ok_out_q, epoch_q == '0,
		"invalid result carries nonzero seconds")
	`HDE_ASSERT_NEXT(a_stage_hold, v_s5 && !en5, v_s5,
		"stalled conversion stage lost its item")

endmodule
